@@ design/upng_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants, register codes and byte helpers for the PNG stream encoder.
package upng_pkg;

    localparam logic [31:0] CRC_POLY            = 32'hEDB8_8320;
    localparam logic [31:0] CRC_AFTER_IHDR      = 32'h575E_51F5;
    localparam logic [31:0] CRC_AFTER_IDAT_ZHDR = 32'h13E5_812D;
    localparam logic [16:0] ADLER_MOD           = 17'd65521;

    localparam int WIDTH_BITS  = 14;
    localparam int HEIGHT_BITS = 16;
    localparam int CFG_BITS    = 16;
    localparam int INDEX_BITS  = 2;

    // Byte positions inside the header, row header and trailer bursts
    localparam logic [5:0] HDR_SIG_LAST   = 6'd15;
    localparam logic [5:0] HDR_CRC_FIRST  = 6'd16;
    localparam logic [5:0] HDR_CRC_LAST   = 6'd28;
    localparam logic [5:0] HDR_LAST       = 6'd42;
    localparam logic [5:0] ROW_LAST       = 6'd5;
    localparam logic [5:0] TRL_ADLER_LAST = 6'd3;
    localparam logic [5:0] TRL_LAST       = 6'd19;

    typedef enum logic [INDEX_BITS-1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_ALPHA  = 2'd2
    } cfg_index_t;

    // One byte through the reflected CRC-32 register.
    function automatic logic [31:0] crc_update(input logic [31:0] crc, input logic [7:0] data);
        logic [31:0] c;
        c = crc ^ {24'h00_0000, data};
        for (int i = 0; i < 8; i++)
        begin
            c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
        end
        return c;
    endfunction

    // PNG signature, then the IHDR length and type.
    function automatic logic [7:0] sig_byte(input logic [3:0] idx);
        logic [7:0] b;
        case (idx)
            4'd0:    b = 8'h89;
            4'd1:    b = 8'h50;
            4'd2:    b = 8'h4E;
            4'd3:    b = 8'h47;
            4'd4:    b = 8'h0D;
            4'd5:    b = 8'h0A;
            4'd6:    b = 8'h1A;
            4'd7:    b = 8'h0A;
            4'd11:   b = 8'h0D;
            4'd12:   b = 8'h49;
            4'd13:   b = 8'h48;
            4'd14:   b = 8'h44;
            4'd15:   b = 8'h52;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

@@ design/uncompressed_png_stream_encoder_core.sv @@
`timescale 1ns / 1ps
// Top level of the uncompressed PNG stream encoder.
//
// Feed raw RGB or RGBA channel bytes, row by row, on the pixel channel; the
// stream channel returns a complete PNG file, one byte per transfer, with
// last set on the final byte caused by each pixel byte. The block emits one PNG
// byte per cycle, while stream_ready allows, through a single output register; a
// pixel byte in the middle of a row yields one byte, the first byte of a row seven
// (six byte stored-block header plus the byte), the first byte of an image fifty
// (file header, IHDR, IDAT head and zlib header, then the row header) and the last
// byte of an image twenty-one (Adler-32, IDAT CRC, IEND). The next pixel byte is
// taken while the last byte of the previous one waits in the output register.
// Write image_width, image_height and has_alpha between images; the IDAT length is
// derived from them through the factor_reg and idat_len_reg registers.
module uncompressed_png_stream_encoder_core
    import upng_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_BITS-1:0]   cfg_data,
    input  logic                  pixel_valid,
    output logic                  pixel_ready,
    input  logic [7:0]            pixel_byte,
    output logic                  stream_valid,
    input  logic                  stream_ready,
    output logic [7:0]            out_byte,
    output logic                  last
);

    typedef enum logic [1:0] {
        SEG_HDR,
        SEG_ROW,
        SEG_DATA,
        SEG_TRL
    } seg_t;

    // configuration
    logic [WIDTH_BITS-1:0]  width_reg, width_next;
    logic [HEIGHT_BITS-1:0] height_reg, height_next;
    logic                   alpha_reg, alpha_next;

    // derived image constants
    logic [WIDTH_BITS-1:0]  w_eff;
    logic [HEIGHT_BITS-1:0] h_eff;
    logic [15:0]            row_bytes;
    logic [15:0]            block_len;
    logic [16:0]            factor_reg, factor_next;
    logic [32:0]            idat_product;
    logic [31:0]            idat_len_reg, idat_len_next;

    // sequencer and handshake
    seg_t        seg_reg, seg_next;
    logic [5:0]  idx_reg, idx_next;
    logic        item_valid_reg, item_valid_next;
    logic [7:0]  item_byte_reg;
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_byte_reg;
    logic        out_last_reg;
    logic        advance;
    logic        load;
    logic [7:0]  cur_byte;
    logic        cur_last;

    // stream state
    logic [31:0] crc_reg, crc_next;
    logic [15:0] adler_low_reg, adler_low_next;
    logic [15:0] adler_high_reg, adler_high_next;
    logic [15:0] col_reg, col_next;
    logic [15:0] row_reg, row_next;
    logic        hdr_done_reg, hdr_done_next;

    logic [16:0] col_inc;
    logic [16:0] row_inc;
    logic        row_end;
    logic        image_end;
    logic        final_row;
    logic [16:0] low_sum, low_diff;
    logic [15:0] low_mod;
    logic [16:0] high_sum, high_diff;
    logic [15:0] high_mod;
    logic [16:0] hrow_sum, hrow_diff;
    logic [15:0] hrow_mod;

    always_comb
    begin
        w_eff        = (width_reg == '0) ? WIDTH_BITS'(1) : width_reg;
        h_eff        = (height_reg == '0) ? HEIGHT_BITS'(1) : height_reg;
        row_bytes    = alpha_reg ? {w_eff, 2'b00} : ({2'b00, w_eff} + {1'b0, w_eff, 1'b0});
        block_len    = row_bytes + 16'd1;
        factor_next  = {1'b0, block_len} + 17'd5;
        idat_product = h_eff * factor_reg;
        idat_len_next = idat_product[31:0] + 32'd6;
    end

    // counters and Adler-32 sums
    always_comb
    begin
        col_inc   = {1'b0, col_reg} + 17'd1;
        row_inc   = {1'b0, row_reg} + 17'd1;
        final_row = row_inc >= {1'b0, h_eff};
        row_end   = col_inc >= {1'b0, row_bytes};
        image_end = row_end && final_row;

        low_sum   = {1'b0, adler_low_reg} + {9'h000, item_byte_reg};
        low_diff  = low_sum - ADLER_MOD;
        low_mod   = (low_sum >= ADLER_MOD) ? low_diff[15:0] : low_sum[15:0];
        high_sum  = {1'b0, adler_high_reg} + {1'b0, low_mod};
        high_diff = high_sum - ADLER_MOD;
        high_mod  = (high_sum >= ADLER_MOD) ? high_diff[15:0] : high_sum[15:0];
        hrow_sum  = {1'b0, adler_high_reg} + {1'b0, adler_low_reg};
        hrow_diff = hrow_sum - ADLER_MOD;
        hrow_mod  = (hrow_sum >= ADLER_MOD) ? hrow_diff[15:0] : hrow_sum[15:0];
    end

    // byte at the current sequencer position
    always_comb
    begin
        cur_byte = 8'h00;
        cur_last = 1'b0;
        unique case (seg_reg)
            SEG_HDR:
            begin
                case (idx_reg) inside
                    [6'd0:6'd15]: cur_byte = sig_byte(idx_reg[3:0]);
                    6'd18:        cur_byte = {2'b00, w_eff[13:8]};
                    6'd19:        cur_byte = w_eff[7:0];
                    6'd22:        cur_byte = h_eff[15:8];
                    6'd23:        cur_byte = h_eff[7:0];
                    6'd24:        cur_byte = 8'h08;
                    6'd25:        cur_byte = alpha_reg ? 8'h06 : 8'h02;
                    6'd29:        cur_byte = ~crc_reg[31:24];
                    6'd30:        cur_byte = ~crc_reg[23:16];
                    6'd31:        cur_byte = ~crc_reg[15:8];
                    6'd32:        cur_byte = ~crc_reg[7:0];
                    6'd33:        cur_byte = idat_len_reg[31:24];
                    6'd34:        cur_byte = idat_len_reg[23:16];
                    6'd35:        cur_byte = idat_len_reg[15:8];
                    6'd36:        cur_byte = idat_len_reg[7:0];
                    6'd37:        cur_byte = 8'h49;
                    6'd38:        cur_byte = 8'h44;
                    6'd39:        cur_byte = 8'h41;
                    6'd40:        cur_byte = 8'h54;
                    6'd41:        cur_byte = 8'h78;
                    6'd42:        cur_byte = 8'h01;
                    default:      cur_byte = 8'h00;
                endcase
            end
            SEG_ROW:
            begin
                case (idx_reg)
                    6'd0:    cur_byte = {7'h00, final_row};
                    6'd1:    cur_byte = block_len[7:0];
                    6'd2:    cur_byte = block_len[15:8];
                    6'd3:    cur_byte = ~block_len[7:0];
                    6'd4:    cur_byte = ~block_len[15:8];
                    default: cur_byte = 8'h00;
                endcase
            end
            SEG_DATA:
            begin
                cur_byte = item_byte_reg;
                cur_last = !image_end;
            end
            SEG_TRL:
            begin
                case (idx_reg) inside
                    6'd0:    cur_byte = adler_high_reg[15:8];
                    6'd1:    cur_byte = adler_high_reg[7:0];
                    6'd2:    cur_byte = adler_low_reg[15:8];
                    6'd3:    cur_byte = adler_low_reg[7:0];
                    6'd4:    cur_byte = ~crc_reg[31:24];
                    6'd5:    cur_byte = ~crc_reg[23:16];
                    6'd6:    cur_byte = ~crc_reg[15:8];
                    6'd7:    cur_byte = ~crc_reg[7:0];
                    6'd12:   cur_byte = 8'h49;
                    6'd13:   cur_byte = 8'h45;
                    6'd14:   cur_byte = 8'h4E;
                    6'd15:   cur_byte = 8'h44;
                    6'd16:   cur_byte = 8'hAE;
                    6'd17:   cur_byte = 8'h42;
                    6'd18:   cur_byte = 8'h60;
                    6'd19:   cur_byte = 8'h82;
                    default: cur_byte = 8'h00;
                endcase
                cur_last = (idx_reg == TRL_LAST);
            end
            default:
            begin
                cur_byte = 8'h00;
                cur_last = 1'b0;
            end
        endcase
    end

    assign advance     = item_valid_reg && (!out_valid_reg || stream_ready);
    assign pixel_ready = !item_valid_reg || (advance && cur_last);
    assign load        = pixel_valid && pixel_ready;

    always_comb
    begin
        width_next      = width_reg;
        height_next     = height_reg;
        alpha_next      = alpha_reg;
        seg_next        = seg_reg;
        idx_next        = idx_reg;
        item_valid_next = item_valid_reg;
        out_valid_next  = out_valid_reg;
        crc_next        = crc_reg;
        adler_low_next  = adler_low_reg;
        adler_high_next = adler_high_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        hdr_done_next   = hdr_done_reg;

        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_WIDTH:  width_next  = cfg_data[WIDTH_BITS-1:0];
                CFG_HEIGHT: height_next = cfg_data[HEIGHT_BITS-1:0];
                CFG_ALPHA:  alpha_next  = cfg_data[0];
                default:    ;
            endcase
        end

        if (advance)
        begin
            out_valid_next = 1'b1;
            idx_next       = idx_reg + 6'd1;
            unique case (seg_reg)
                SEG_HDR:
                begin
                    // the CRC runs only over the IHDR payload; constants cover the rest
                    if (idx_reg == HDR_SIG_LAST)
                    begin
                        crc_next = CRC_AFTER_IHDR;
                    end
                    else if (idx_reg >= HDR_CRC_FIRST && idx_reg <= HDR_CRC_LAST)
                    begin
                        crc_next = crc_update(crc_reg, cur_byte);
                    end
                    if (idx_reg == HDR_LAST)
                    begin
                        crc_next      = CRC_AFTER_IDAT_ZHDR;
                        hdr_done_next = 1'b1;
                        seg_next      = SEG_ROW;
                        idx_next      = '0;
                    end
                end
                SEG_ROW:
                begin
                    crc_next = crc_update(crc_reg, cur_byte);
                    if (idx_reg == ROW_LAST)
                    begin
                        // filter byte enters the Adler sums as a zero
                        adler_high_next = hrow_mod;
                        seg_next        = SEG_DATA;
                        idx_next        = '0;
                    end
                end
                SEG_DATA:
                begin
                    crc_next        = crc_update(crc_reg, cur_byte);
                    adler_low_next  = low_mod;
                    adler_high_next = high_mod;
                    idx_next        = '0;
                    if (row_end)
                    begin
                        col_next = '0;
                        row_next = row_inc[15:0];
                    end
                    else
                    begin
                        col_next = col_inc[15:0];
                    end
                    if (image_end)
                    begin
                        seg_next = SEG_TRL;
                    end
                end
                SEG_TRL:
                begin
                    if (idx_reg <= TRL_ADLER_LAST)
                    begin
                        crc_next = crc_update(crc_reg, cur_byte);
                    end
                    if (idx_reg == TRL_LAST)
                    begin
                        // file done: start the next byte on a fresh file
                        crc_next        = '0;
                        adler_low_next  = 16'd1;
                        adler_high_next = '0;
                        col_next        = '0;
                        row_next        = '0;
                        hdr_done_next   = 1'b0;
                    end
                end
                default: ;
            endcase
            if (cur_last)
            begin
                item_valid_next = 1'b0;
            end
        end
        else if (out_valid_reg && stream_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (load)
        begin
            item_valid_next = 1'b1;
            idx_next        = '0;
            if (!hdr_done_next)
            begin
                seg_next = SEG_HDR;
            end
            else if (col_next == '0)
            begin
                seg_next = SEG_ROW;
            end
            else
            begin
                seg_next = SEG_DATA;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg      <= WIDTH_BITS'(1);
            height_reg     <= HEIGHT_BITS'(1);
            alpha_reg      <= 1'b0;
            seg_reg        <= SEG_HDR;
            idx_reg        <= '0;
            item_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_byte_reg   <= 8'h00;
            out_last_reg   <= 1'b0;
            crc_reg        <= '0;
            adler_low_reg  <= 16'd1;
            adler_high_reg <= '0;
            col_reg        <= '0;
            row_reg        <= '0;
            hdr_done_reg   <= 1'b0;
        end
        else
        begin
            width_reg      <= width_next;
            height_reg     <= height_next;
            alpha_reg      <= alpha_next;
            seg_reg        <= seg_next;
            idx_reg        <= idx_next;
            item_valid_reg <= item_valid_next;
            out_valid_reg  <= out_valid_next;
            if (advance)
            begin
                out_byte_reg <= cur_byte;
                out_last_reg <= cur_last;
            end
            crc_reg        <= crc_next;
            adler_low_reg  <= adler_low_next;
            adler_high_reg <= adler_high_next;
            col_reg        <= col_next;
            row_reg        <= row_next;
            hdr_done_reg   <= hdr_done_next;
        end
    end

    // payload and derived constants, no reset
    always_ff @(posedge clk)
    begin
        factor_reg   <= factor_next;
        idat_len_reg <= idat_len_next;
        if (load)
        begin
            item_byte_reg <= pixel_byte;
        end
    end

    assign stream_valid = out_valid_reg;
    assign out_byte     = out_byte_reg;
    assign last         = out_last_reg;

endmodule

@@ design/upng_checker.sv @@
`timescale 1ns / 1ps
// Port-level checker for the PNG stream encoder, bound to the top level.
module upng_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       pixel_valid,
    input logic       pixel_ready,
    input logic       stream_valid,
    input logic       stream_ready,
    input logic [7:0] out_byte,
    input logic       last
);

    logic       in_xfer;
    logic       end_xfer;
    logic [2:0] pending_reg, pending_next;

    assign in_xfer  = pixel_valid && pixel_ready;
    assign end_xfer = stream_valid && stream_ready && last;

    // pixel bytes taken whose final stream byte has not yet been transferred
    always_comb
    begin
        pending_next = pending_reg;
        if (in_xfer && !end_xfer)
        begin
            pending_next = pending_reg + 3'd1;
        end
        else if (!in_xfer && end_xfer)
        begin
            pending_next = pending_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        stream_valid && !stream_ready |=> stream_valid && $stable(out_byte) && $stable(last))
        else $error("stalled stream byte changed");

    a_no_invented_output: assert property (@(posedge clk) disable iff (!rst_n)
        stream_valid |-> pending_reg != 3'd0)
        else $error("stream byte with no pixel byte in flight");

    a_at_most_two: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= 3'd2)
        else $error("more than two pixel bytes in flight");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg == 3'd0 |-> pixel_ready)
        else $error("pixel channel blocked with nothing in flight");

endmodule

bind uncompressed_png_stream_encoder_core upng_checker u_checker (.*);

@@ tb/tb_uncompressed_png_stream_encoder_core.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the uncompressed PNG stream encoder core.
module tb_uncompressed_png_stream_encoder_core;
    import upng_pkg::*;

    localparam int STALL_LIMIT   = 3000;
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_CYCLES  = 64;
    localparam int REPORT_LINES  = 100;

    // PNG file format bytes
    localparam logic [127:0] PNG_LEAD    = 128'h8950_4E47_0D0A_1A0A_0000_000D_4948_4452;
    localparam logic [31:0]  IDAT_TYPE   = 32'h4944_4154;
    localparam logic [31:0]  IEND_TYPE   = 32'h4945_4E44;
    localparam logic [31:0]  IEND_CRC    = 32'hAE42_6082;
    localparam logic [7:0]   ZLIB_CMF    = 8'h78;
    localparam logic [7:0]   ZLIB_FLG    = 8'h01;
    localparam logic [7:0]   BIT_DEPTH   = 8'd8;
    localparam logic [7:0]   COLOR_RGB   = 8'd2;
    localparam logic [7:0]   COLOR_RGBA  = 8'd6;
    localparam logic [7:0]   FILTER_NONE = 8'd0;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } png_byte_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [INDEX_BITS-1:0] cfg_index = CFG_WIDTH;
    logic [CFG_BITS-1:0]   cfg_data = '0;
    logic                  pixel_valid = 1'b0;
    logic                  pixel_ready;
    logic [7:0]            pixel_byte = 8'h00;
    logic                  stream_valid;
    logic                  stream_ready = 1'b0;
    logic [7:0]            out_byte;
    logic                  last;

    // Predictor copy of the registers and the encoder state
    logic [13:0]  fmt_width;
    logic [15:0]  fmt_height;
    logic         fmt_alpha;
    logic [31:0]  crc_acc;
    int unsigned  adler_a;
    int unsigned  adler_b;
    int unsigned  col_count;
    int unsigned  row_count;
    logic         hdr_sent;

    png_byte_t    png_bytes_due[$];
    png_byte_t    burst_q[$];
    png_byte_t    want_byte;

    int           send_idle = 0;
    int           recv_idle = 0;
    int           err_count = 0;
    int unsigned  out_index = 0;
    int           stall_cycles = 0;

    uncompressed_png_stream_encoder_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .pixel_valid  (pixel_valid),
        .pixel_ready  (pixel_ready),
        .pixel_byte   (pixel_byte),
        .stream_valid (stream_valid),
        .stream_ready (stream_ready),
        .out_byte     (out_byte),
        .last         (last)
    );

    always #5 clk = ~clk;

    task automatic report_mismatch(input string what, input int unsigned index,
                                   input logic [7:0] got, input logic [7:0] want);
        if (err_count < REPORT_LINES)
        begin
            $display("MISMATCH %s at stream byte %0d: got %02h expected %02h (%0t)",
                     what, index, got, want, $realtime);
        end
        err_count++;
    endtask

    task automatic clear_encoder_state();
        crc_acc   = 32'h0;
        adler_a   = 1;
        adler_b   = 0;
        col_count = 0;
        row_count = 0;
        hdr_sent  = 1'b0;
    endtask

    // Queue one PNG byte of the current burst and run it through the CRC.
    task automatic push_png(input logic [31:0] value);
        png_byte_t entry;
        int        k;
        entry.data = value[7:0];
        entry.last = 1'b0;
        if (burst_q.size() < 50)
        begin
            burst_q.push_back(entry);
        end
        crc_acc = crc_acc ^ {24'h0, value[7:0]};
        for (k = 0; k < 8; k++)
        begin
            crc_acc = (crc_acc >> 1) ^ (CRC_POLY & {32{crc_acc[0]}});
        end
    endtask

    task automatic push_be32(input logic [31:0] value);
        push_png(value >> 24);
        push_png(value >> 16);
        push_png(value >> 8);
        push_png(value);
    endtask

    // Work out the PNG bytes that one accepted pixel byte produces.
    task automatic encode_pixel_byte(input logic [7:0] value);
        int unsigned w;
        int unsigned h;
        int unsigned row_bytes;
        int unsigned block_len;
        int unsigned k;
        png_byte_t   tail;
        w = (fmt_width == 0) ? 1 : fmt_width;
        h = (fmt_height == 0) ? 1 : fmt_height;
        row_bytes = w * (fmt_alpha ? 4 : 3);
        block_len = row_bytes + 1;
        burst_q.delete();
        if (!hdr_sent)
        begin
            for (k = 0; k < 16; k++)
            begin
                push_png(32'(PNG_LEAD[127 - 8*k -: 8]));
            end
            crc_acc = CRC_AFTER_IHDR;
            push_be32(w);
            push_be32(h);
            push_png(32'(BIT_DEPTH));
            push_png(32'(fmt_alpha ? COLOR_RGBA : COLOR_RGB));
            push_png(0);
            push_png(0);
            push_png(0);
            push_be32(~crc_acc);
            push_be32(h * (block_len + 5) + 6);
            push_be32(IDAT_TYPE);
            push_png(32'(ZLIB_CMF));
            push_png(32'(ZLIB_FLG));
            crc_acc  = CRC_AFTER_IDAT_ZHDR;
            hdr_sent = 1'b1;
        end
        if (col_count == 0)
        begin
            push_png((row_count + 1 >= h) ? 1 : 0);
            push_png(block_len);
            push_png(block_len >> 8);
            push_png(~block_len);
            push_png(~block_len >> 8);
            push_png(32'(FILTER_NONE));
            adler_b = adler_b + adler_a;
            if (adler_b >= ADLER_MOD)
            begin
                adler_b = adler_b - ADLER_MOD;
            end
        end
        push_png(32'(value));
        adler_a = adler_a + value;
        if (adler_a >= ADLER_MOD)
        begin
            adler_a = adler_a - ADLER_MOD;
        end
        adler_b = adler_b + adler_a;
        if (adler_b >= ADLER_MOD)
        begin
            adler_b = adler_b - ADLER_MOD;
        end
        col_count++;
        if (col_count >= row_bytes)
        begin
            col_count = 0;
            row_count++;
            if (row_count >= h)
            begin
                push_png(adler_b >> 8);
                push_png(adler_b);
                push_png(adler_a >> 8);
                push_png(adler_a);
                push_be32(~crc_acc);
                push_be32(0);
                push_be32(IEND_TYPE);
                push_be32(IEND_CRC);
                clear_encoder_state();
            end
        end
        tail = burst_q.pop_back();
        tail.last = 1'b1;
        burst_q.push_back(tail);
        foreach (burst_q[i])
        begin
            png_bytes_due.push_back(burst_q[i]);
        end
    endtask

    // Offer one pixel byte and hold it until the transfer happens.
    task automatic send_pixel(input logic [7:0] value);
        while ($urandom_range(99) < send_idle)
        begin
            pixel_valid <= 1'b0;
            @(posedge clk);
        end
        pixel_valid <= 1'b1;
        pixel_byte  <= value;
        @(posedge clk);
        while (!pixel_ready)
        begin
            @(posedge clk);
        end
        encode_pixel_byte(value);
    endtask

    task automatic wait_stream_drained();
        pixel_valid <= 1'b0;
        while (png_bytes_due.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [15:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        case (idx)
            CFG_WIDTH:  fmt_width  = value[13:0];
            CFG_HEIGHT: fmt_height = value;
            CFG_ALPHA:  fmt_alpha  = value[0];
            default:    ;
        endcase
    endtask

    // Program all three registers once the output has gone quiet.
    task automatic write_image_format(input logic [15:0] width, input logic [15:0] height,
                                      input logic alpha);
        wait_stream_drained();
        write_reg(CFG_WIDTH, width);
        write_reg(CFG_HEIGHT, height);
        write_reg(CFG_ALPHA, {15'h0, alpha});
        cfg_we <= 1'b0;
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Reset values: one RGB pixel, one row.
    task automatic test_default_format();
        send_pixel(8'h00);
        send_pixel(8'hFF);
        send_pixel(8'hA5);
    endtask

    // A register value of zero acts as one.
    task automatic test_zero_dimensions();
        write_image_format(16'd0, 16'd0, 1'b1);
        send_pixel(8'h5A);
        send_pixel(8'hC3);
        send_pixel(8'h01);
        send_pixel(8'h80);
    endtask

    // Widest rows and a height that wraps the IDAT length, then shrink mid-image.
    task automatic test_extreme_dimensions();
        write_image_format(16'hFFFF, 16'hFFFF, 1'b1);
        send_pixel(8'hFF);
        send_pixel(8'h00);
        send_pixel(8'h7F);
        send_pixel(8'hFE);
        write_image_format(16'd1, 16'd1, 1'b1);
        send_pixel(8'h55);
        write_image_format(16'd2, 16'd32768, 1'b0);
        send_pixel(8'hAA);
        send_pixel(8'h33);
        write_image_format(16'd1, 16'd1, 1'b0);
        send_pixel(8'hCC);
    endtask

    // Two rows: only the second block header carries the final flag.
    task automatic test_multi_row();
        write_image_format(16'd1, 16'd2, 1'b0);
        send_pixel(8'h10);
        send_pixel(8'hEF);
        send_pixel(8'h01);
        send_pixel(8'hFD);
        send_pixel(8'h80);
        send_pixel(8'h7E);
    endtask

    // Whole random images of small random formats, some reformatted mid-image.
    task automatic test_random_stream(input int byte_budget, input int sender_idle,
                                      input int receiver_idle);
        int sent;
        int in_image;
        int cut;
        send_idle = sender_idle;
        recv_idle = receiver_idle;
        sent = 0;
        while (sent < byte_budget)
        begin
            if ($urandom_range(2) != 0)
            begin
                write_image_format(16'(($urandom_range(9) == 0) ? 0 : $urandom_range(1, 4)),
                                   16'(($urandom_range(9) == 0) ? 0 : $urandom_range(1, 3)),
                                   1'($urandom_range(1)));
            end
            cut = ($urandom_range(7) == 0) ? $urandom_range(1, 6) : -1;
            in_image = 0;
            send_pixel(8'($urandom_range(255)));
            sent++;
            in_image++;
            while (hdr_sent)
            begin
                if (in_image == cut)
                begin
                    write_image_format(16'($urandom_range(1, 3)), 16'($urandom_range(1, 2)),
                                       1'($urandom_range(1)));
                end
                send_pixel(8'($urandom_range(255)));
                sent++;
                in_image++;
            end
        end
    endtask

    // Check each stream transfer against the oldest expected byte; drive ready.
    always @(posedge clk)
    begin
        if (rst_n && stream_valid && stream_ready)
        begin
            if (png_bytes_due.size() == 0)
            begin
                report_mismatch("unexpected byte", out_index, out_byte, 8'h00);
            end
            else
            begin
                want_byte = png_bytes_due.pop_front();
                if (out_byte !== want_byte.data)
                begin
                    report_mismatch("out_byte", out_index, out_byte, want_byte.data);
                end
                if (last !== want_byte.last)
                begin
                    report_mismatch("last", out_index, {7'h0, last}, {7'h0, want_byte.last});
                end
            end
            out_index++;
        end
        stream_ready <= ($urandom_range(99) >= recv_idle);
    end

    // End the run when nothing transfers for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (pixel_valid && pixel_ready) || (stream_valid && stream_ready))
        begin
            stall_cycles <= 0;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("uncompressed_png_stream_encoder_core verification failed");
            $finish;
        end
    end

    initial
    begin
        fmt_width  = 14'd1;
        fmt_height = 16'd1;
        fmt_alpha  = 1'b0;
        clear_encoder_state();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_idle = 36;
        recv_idle = 48;
        test_default_format();
        test_zero_dimensions();
        test_extreme_dimensions();
        test_multi_row();
        test_random_stream(142, 36, 48);
        test_random_stream(142, 48, 36);
        test_random_stream(142, 0, 0);
        wait_stream_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_count == 0 && png_bytes_due.size() == 0)
        begin
            $display("uncompressed_png_stream_encoder_core verification clean");
        end
        else
        begin
            $display("uncompressed_png_stream_encoder_core verification failed");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
design/upng_pkg.sv
design/uncompressed_png_stream_encoder_core.sv
design/upng_checker.sv
tb/tb_uncompressed_png_stream_encoder_core.sv
